// ===== design/md5he_pkg.sv =====
package md5he_pkg;

  // chain value words, word 0 in the low 32 bits
  typedef logic [3:0][31:0] chain_t;

  // write request into the block buffer
  typedef struct packed {
    logic        en;
    logic [3:0]  addr;
    logic [31:0] data;
  } blk_wr_t;

  localparam chain_t MD5_IV = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};

  localparam logic [31:0] PAD_MARK_WORD = 32'h0000_0080;

  localparam logic [31:0] K_TAB [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  // indexed by {round, step[1:0]}
  localparam logic [4:0] ROT_TAB [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  function automatic logic [31:0] md5_k(input logic [5:0] idx);
    return K_TAB[idx];
  endfunction

  function automatic logic [4:0] md5_rot(input logic [5:0] idx);
    return ROT_TAB[{idx[5:4], idx[1:0]}];
  endfunction

  // message word used by a step
  function automatic logic [3:0] md5_g(input logic [5:0] idx);
    logic [3:0] i4;
    logic [3:0] g;
    i4 = idx[3:0];
    case (idx[5:4])
      2'd0:    g = i4;
      2'd1:    g = i4 * 4'd5 + 4'd1;
      2'd2:    g = i4 * 4'd3 + 4'd5;
      default: g = i4 * 4'd7;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] md5_f(input logic [1:0] rnd, input logic [31:0] b,
                                        input logic [31:0] c, input logic [31:0] d);
    logic [31:0] f;
    case (rnd)
      2'd0:    f = d ^ (b & (c ^ d));
      2'd1:    f = c ^ (d & (b ^ c));
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    return f;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

// ===== design/md5he_round.sv =====
module md5he_round
  import md5he_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  blk_wr_t wr,
  input  logic    start,
  input  chain_t  chain_in,
  output logic    done,
  output chain_t  chain_out
);

  logic [31:0] mem [16];
  logic [31:0] rd_data_r;
  logic        run_r;
  logic [6:0]  cnt_r;
  logic [31:0] a_r, b_r, c_r, d_r, pre_r;

  logic        rd_en, pre_en, exe_en;
  logic [5:0]  pre_idx, exe_idx;
  logic [31:0] pre_a, f_val, b_nxt;

  // read issued ahead into rd_data_r; pre_r holds a + K + M for the next step
  assign rd_en   = run_r && !cnt_r[6];
  assign pre_idx = 6'(cnt_r - 7'd1);
  assign exe_idx = 6'(cnt_r - 7'd2);
  assign pre_en  = run_r && (cnt_r >= 7'd1) && (cnt_r <= 7'd64);
  assign exe_en  = run_r && (cnt_r >= 7'd2) && (cnt_r <= 7'd65);
  assign done    = run_r && (cnt_r == 7'd66);

  // before the first step a comes from the loaded state, later it is the current d
  assign pre_a = (cnt_r == 7'd1) ? a_r : d_r;
  assign f_val = md5_f(exe_idx[5:4], b_r, c_r, d_r);
  assign b_nxt = b_r + rotl32(pre_r + f_val, md5_rot(exe_idx));

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      rd_data_r <= mem[md5_g(cnt_r[5:0])];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      cnt_r <= '0;
    end else if (start) begin
      run_r <= 1'b1;
      cnt_r <= '0;
    end else if (done) begin
      run_r <= 1'b0;
    end else if (run_r) begin
      cnt_r <= cnt_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= chain_in[0];
      b_r <= chain_in[1];
      c_r <= chain_in[2];
      d_r <= chain_in[3];
    end else if (exe_en) begin
      a_r <= d_r;
      b_r <= b_nxt;
      c_r <= b_r;
      d_r <= c_r;
    end
    if (pre_en) begin
      pre_r <= pre_a + md5_k(pre_idx) + rd_data_r;
    end
  end

  assign chain_out[0] = chain_in[0] + a_r;
  assign chain_out[1] = chain_in[1] + b_r;
  assign chain_out[2] = chain_in[2] + c_r;
  assign chain_out[3] = chain_in[3] + d_r;

  a_no_write_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !wr.en)
    else $error("block buffer written during compression");

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    run_r |-> !start)
    else $error("compression restarted while running");

  a_done_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !run_r)
    else $error("compression still running after done");

endmodule

// ===== design/md5_hash_engine_unit.sv =====
// MD5 hasher. Message words enter on in_* (bytes little-endian, in_tuser = valid byte count,
// values above four count as four; in_tlast ends the message, an empty last word is legal).
// Words are taken one per cycle while in_tready is high, which is only in the idle state; each
// completed 64-byte block then runs through the compression unit, one MD5 step per cycle, with
// the message word for each step read from a 16-word block memory ahead of that step. The last
// word starts padding, which takes one or two block compressions, after which the digest is
// handed to the output buffer. The digest leaves as four words on out_* (out_tuser = word
// index, out_tlast on word 3) from that buffer, so the next message is accepted while the
// digest drains.
module md5_hash_engine_unit
  import md5he_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] data_word
  input  logic [2:0]  in_tuser,   // [2:0] byte_count
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [1:0]  out_tuser,  // [1:0] word_index
  output logic        out_tlast
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_MARK   = 8'b0000_0010,
    S_ZERO   = 8'b0000_0100,
    S_LENLO  = 8'b0000_1000,
    S_LENHI  = 8'b0001_0000,
    S_COMP   = 8'b0010_0000,
    S_DIGEST = 8'b0100_0000,
    S_SPARE  = 8'b1000_0000
  } state_t;

  state_t      state_r, ret_r, phase_nxt;
  logic [5:0]  fill_r;
  logic [31:0] part_r;
  logic [63:0] len_r;
  chain_t      chain_r, dig_r, chain_out;
  logic        out_busy_r;
  logic [1:0]  out_idx_r;

  logic        absorb, wr_word, block_done, core_done;
  logic [31:0] src_word, word_m;
  logic [2:0]  src_cnt, sum3;
  logic [1:0]  off;
  logic [63:0] comb64, bits;
  blk_wr_t     blk_wr;

  assign in_tready = (state_r == S_IDLE);
  assign off       = fill_r[1:0];
  assign bits      = {len_r[60:0], 3'b000};

  always_comb begin
    src_word  = '0;
    src_cnt   = '0;
    absorb    = 1'b0;
    phase_nxt = S_IDLE;
    unique case (state_r)
      S_IDLE: begin
        src_word  = in_tdata;
        src_cnt   = (in_tuser > 3'd4) ? 3'd4 : in_tuser;
        absorb    = in_tvalid;
        phase_nxt = in_tlast ? S_MARK : S_IDLE;
      end
      S_MARK: begin
        src_word  = PAD_MARK_WORD;
        src_cnt   = 3'd1;
        absorb    = 1'b1;
        phase_nxt = S_ZERO;
      end
      S_ZERO: begin
        // zeros up to the next word boundary until 56 bytes are in the block
        src_cnt   = 3'd4 - {1'b0, off};
        absorb    = (fill_r != 6'd56);
        phase_nxt = S_ZERO;
      end
      S_LENLO: begin
        src_word  = bits[31:0];
        src_cnt   = 3'd4;
        absorb    = 1'b1;
        phase_nxt = S_LENHI;
      end
      S_LENHI: begin
        src_word  = bits[63:32];
        src_cnt   = 3'd4;
        absorb    = 1'b1;
        phase_nxt = S_DIGEST;
      end
      default: begin
        absorb = 1'b0;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      word_m[8*i +: 8] = (3'(i) < src_cnt) ? src_word[8*i +: 8] : 8'h00;
    end
  end

  // part_r keeps the bytes of the partly filled word, bytes above off are zero
  assign comb64     = {32'h0, part_r} | ({32'h0, word_m} << {off, 3'b000});
  assign sum3       = {1'b0, off} + src_cnt;
  assign wr_word    = sum3[2];
  assign block_done = absorb && wr_word && (fill_r[5:2] == 4'hf);

  assign blk_wr.en   = absorb && wr_word;
  assign blk_wr.addr = fill_r[5:2];
  assign blk_wr.data = comb64[31:0];

  md5he_round u_round (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr        (blk_wr),
    .start     (block_done),
    .chain_in  (chain_r),
    .done      (core_done),
    .chain_out (chain_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      ret_r      <= S_IDLE;
      fill_r     <= '0;
      part_r     <= '0;
      len_r      <= '0;
      chain_r    <= MD5_IV;
      out_busy_r <= 1'b0;
      out_idx_r  <= '0;
    end else begin
      if (absorb) begin
        fill_r  <= fill_r + {3'b000, src_cnt};
        part_r  <= wr_word ? comb64[63:32] : comb64[31:0];
        ret_r   <= phase_nxt;
        state_r <= block_done ? S_COMP : phase_nxt;
        if (state_r == S_IDLE) begin
          len_r <= len_r + {61'd0, src_cnt};
        end
      end else begin
        unique case (state_r)
          S_ZERO: begin
            state_r <= S_LENLO;
          end
          S_COMP: begin
            if (core_done) begin
              chain_r <= chain_out;
              state_r <= ret_r;
            end
          end
          S_DIGEST: begin
            if (!out_busy_r) begin
              chain_r    <= MD5_IV;
              fill_r     <= '0;
              part_r     <= '0;
              len_r      <= '0;
              out_busy_r <= 1'b1;
              out_idx_r  <= '0;
              state_r    <= S_IDLE;
            end
          end
          default: begin
            state_r <= state_r;
          end
        endcase
      end

      if (out_busy_r && out_tready) begin
        out_idx_r <= out_idx_r + 2'd1;
        if (out_idx_r == 2'd3) begin
          out_busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DIGEST) && !out_busy_r) begin
      dig_r <= chain_r;
    end else if (out_busy_r && out_tready) begin
      dig_r <= {32'h0, dig_r[3:1]};
    end
  end

  assign out_tvalid = out_busy_r;
  assign out_tdata  = dig_r[0];
  assign out_tuser  = out_idx_r;
  assign out_tlast  = (out_idx_r == 2'd3);

  a_len_at_block_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LENHI) |-> (fill_r == 6'd60))
    else $error("length high word not at end of block");

  a_digest_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGEST) |-> (fill_r == 6'd0) && (part_r == 32'h0))
    else $error("digest with bytes left in block buffer");

  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> (state_r == S_COMP))
    else $error("compression finished outside compress state");

  a_no_input_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMP) |-> !absorb)
    else $error("bytes absorbed during compression");

endmodule

// ===== sim/tb_md5_hash_engine_unit.sv =====
module tb_md5_hash_engine_unit;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [3:0][31:0] digest_t;

  typedef struct packed {
    logic [31:0] data;
    logic [2:0]  cnt;
    logic        last;
    logic        known;   // digest typed in below instead of predicted
    digest_t     digest;
  } stim_row_t;

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  idx;
    logic        fin;
  } digest_beat_t;

  localparam int DIR_ROWS     = 22;
  localparam int RAND_ITEMS   = 332;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 300;

  localparam digest_t MD5_START    = {32'h10325476, 32'h98badcfe, 32'hefcdab89, 32'h67452301};
  localparam digest_t EMPTY_DIGEST = {32'h7e42f8ec, 32'h980980e9, 32'h04b2008f, 32'hd98c1dd4};
  localparam digest_t ABC_DIGEST   = {32'h727fe128, 32'h7d3f96d6, 32'hb04fd23c, 32'h98500190};
  localparam digest_t NO_DIGEST    = '0;

  localparam logic [31:0] SINE_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam int ROT_BY [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

  // empty message, "abc", oversized counts, partial and empty words mid-message,
  // a 61-byte message whose padding spills into a second block
  stim_row_t stim_rows [DIR_ROWS] = '{
    '{32'hffffffff, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST},
    '{32'hff636261, 3'd3, 1'b1, 1'b1, ABC_DIGEST},
    '{32'h00000000, 3'd7, 1'b1, 1'b0, NO_DIGEST},
    '{32'hffffffff, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'h01234567, 3'd5, 1'b0, 1'b0, NO_DIGEST},
    '{32'h89abcdef, 3'd6, 1'b0, 1'b0, NO_DIGEST},
    '{32'h76543210, 3'd7, 1'b0, 1'b0, NO_DIGEST},
    '{32'h00000000, 3'd3, 1'b0, 1'b0, NO_DIGEST},
    '{32'ha5a5a5a5, 3'd1, 1'b0, 1'b0, NO_DIGEST},
    '{32'h5a5a5a5a, 3'd2, 1'b0, 1'b0, NO_DIGEST},
    '{32'h12345678, 3'd0, 1'b0, 1'b0, NO_DIGEST},
    '{32'h00000000, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'hffffffff, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'h80000001, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'h7ffffffe, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'h0f0f0f0f, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'hf0f0f0f0, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'h33333333, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'hcccccccc, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'h2468ace0, 3'd4, 1'b0, 1'b0, NO_DIGEST},
    '{32'h13579bdf, 3'd3, 1'b1, 1'b0, NO_DIGEST},
    '{32'h00000000, 3'd0, 1'b1, 1'b1, EMPTY_DIGEST}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;
  logic [2:0]  in_tuser;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  // predictor state
  digest_t      chain_h;
  logic [31:0]  blk_w [16];
  logic [5:0]   blk_fill;
  logic [63:0]  msg_len;

  digest_beat_t digest_q [$];
  digest_beat_t want_beat;
  int           errors = 0;
  int           stall_cycles = 0;
  logic         in_pace = 1'b1;
  logic         out_pace = 1'b1;

  md5_hash_engine_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic logic [31:0] rot_left(input logic [31:0] x, input int s);
    return (x << s) | (x >> (32 - s));
  endfunction

  task automatic compress_block();
    logic [31:0] a, b, c, d, f, tmp, sum;
    int g, rnd, i;
    a = chain_h[0];
    b = chain_h[1];
    c = chain_h[2];
    d = chain_h[3];
    for (i = 0; i < 64; i++) begin
      rnd = i / 16;
      case (rnd)
        0: begin
          f = d ^ (b & (c ^ d));
          g = i;
        end
        1: begin
          f = c ^ (d & (b ^ c));
          g = (5 * i + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * i + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * i) % 16;
        end
      endcase
      sum = a + f + SINE_K[i] + blk_w[g];
      tmp = d;
      d = c;
      c = b;
      b = b + rot_left(sum, ROT_BY[rnd * 4 + i % 4]);
      a = tmp;
    end
    chain_h[0] = chain_h[0] + a;
    chain_h[1] = chain_h[1] + b;
    chain_h[2] = chain_h[2] + c;
    chain_h[3] = chain_h[3] + d;
  endtask

  task automatic absorb_byte(input logic [7:0] v);
    blk_w[blk_fill[5:2]][{blk_fill[1:0], 3'b000} +: 8] = v;
    blk_fill = blk_fill + 6'd1;
    if (blk_fill == 6'd0) begin
      compress_block();
    end
  endtask

  task automatic md5_predict_word(input logic [31:0] data, input logic [2:0] cnt,
                                  input logic last, output digest_t dig);
    logic [63:0] bit_len;
    int n, k;
    n = (cnt > 3'd4) ? 4 : int'(cnt);
    for (k = 0; k < n; k++) begin
      absorb_byte(data[8 * k +: 8]);
      msg_len = msg_len + 64'd1;
    end
    dig = chain_h;
    if (last) begin
      bit_len = msg_len << 3;
      absorb_byte(8'h80);
      while (blk_fill != 6'd56) absorb_byte(8'h00);
      for (k = 0; k < 8; k++) absorb_byte(bit_len[8 * k +: 8]);
      dig = chain_h;
      chain_h = MD5_START;
      blk_fill = '0;
      msg_len = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // one request on the input side, with a random hold-off in paced stretches
  task automatic send_word(input logic [31:0] data, input logic [2:0] cnt, input logic last,
                           input logic known, input digest_t known_dig);
    int gap, k;
    digest_t dig;
    if ($urandom_range(0, 3) == 0) in_pace = !in_pace;
    gap = in_pace ? $urandom_range(0, 16) : 0;
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tdata  = data;
    in_tuser  = cnt;
    in_tlast  = last;
    in_tvalid = 1'b1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    md5_predict_word(data, cnt, last, dig);
    if (last) begin
      if (known) dig = known_dig;
      for (k = 0; k < 4; k++) digest_q.push_back('{dig[k], 2'(k), k == 3});
    end
    @(negedge clk);
  endtask

  initial begin
    int sent, words, w, r;
    logic [2:0] cnt;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    rst_n     = 1'b0;
    chain_h   = MD5_START;
    blk_fill  = '0;
    msg_len   = '0;
    for (r = 0; r < 16; r++) blk_w[r] = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    for (r = 0; r < DIR_ROWS; r++) begin
      send_word(stim_rows[r].data, stim_rows[r].cnt, stim_rows[r].last,
                stim_rows[r].known, stim_rows[r].digest);
    end

    // random messages, mostly short, now and then a multi-block one
    sent = 0;
    while (sent < RAND_ITEMS) begin
      words = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40) : $urandom_range(0, 18);
      for (w = 0; w < words; w++) begin
        cnt = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7)) : 3'd4;
        send_word($urandom, cnt, 1'b0, 1'b0, NO_DIGEST);
        sent++;
      end
      send_word($urandom, 3'($urandom_range(0, 7)), 1'b1, 1'b0, NO_DIGEST);
      sent++;
    end
    in_tvalid = 1'b0;

    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // result side backpressure
  initial begin
    int gap;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if ($urandom_range(0, 3) == 0) out_pace = !out_pace;
      gap = out_pace ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
        out_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready = 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("unexpected digest word", out_tdata, '0);
      end else begin
        want_beat = digest_q.pop_front();
        if (out_tdata !== want_beat.word) report_mismatch("digest_word", out_tdata, want_beat.word);
        if (out_tuser !== want_beat.idx) begin
          report_mismatch("word_index", 32'(out_tuser), 32'(want_beat.idx));
        end
        if (out_tlast !== want_beat.fin) begin
          report_mismatch("digest_last", 32'(out_tlast), 32'(want_beat.fin));
        end
      end
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("simulation failed");
    $finish;
  end

endmodule
